@@ hw/rtl/ufd_pkg.sv @@
package ufd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_HIGH = 3'b100
    } escape_phase_t;

    typedef struct packed {
        logic          value_part;
        escape_phase_t escape_phase;
        logic [3:0]    high_nibble;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        value_part:   1'b0,
        escape_phase: ESC_NONE,
        high_nibble:  4'd0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_value;
        logic       pair_end;
        logic       pair_has_value;
        logic       final_res;
    } dec_result_t;

    // A byte that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            d = 4'(c[3:0] + 4'd9);
        end
        return d;
    endfunction

    // Byte produced by an escape cut short; missing digits are zero.
    function automatic logic [7:0] cut_escape(input dec_state_t st);
        logic [7:0] b;
        b = 8'd0;
        if (st.escape_phase == ESC_HIGH) begin
            b = {st.high_nibble, 4'd0};
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/ufd_step.sv @@
module ufd_step (
    input  ufd_pkg::dec_state_t  state,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output ufd_pkg::dec_state_t  state_next,
    output ufd_pkg::dec_result_t result,
    output logic                 emit
);

    always_comb begin
        state_next = state;
        result     = '0;
        emit       = 1'b0;

        if (in_byte == ufd_pkg::CHAR_AMP) begin
            if (state.escape_phase != ufd_pkg::ESC_NONE) begin
                result.out_byte   = ufd_pkg::cut_escape(state);
                result.byte_valid = 1'b1;
                result.is_value   = 1'b1;
            end
            result.pair_end       = 1'b1;
            result.pair_has_value = state.value_part;
            emit                  = 1'b1;
            state_next            = ufd_pkg::STATE_RESET;
        end else if (!state.value_part) begin
            if (in_byte == ufd_pkg::CHAR_EQUALS) begin
                state_next.value_part = 1'b1;
            end else begin
                result.out_byte   = in_byte;
                result.byte_valid = 1'b1;
                emit              = 1'b1;
            end
        end else begin
            case (state.escape_phase)
                ufd_pkg::ESC_NONE: begin
                    if (in_byte == ufd_pkg::CHAR_PERCENT) begin
                        state_next.escape_phase = ufd_pkg::ESC_PCT;
                    end else begin
                        result.out_byte   = (in_byte == ufd_pkg::CHAR_PLUS) ?
                                            ufd_pkg::CHAR_SPACE : in_byte;
                        result.byte_valid = 1'b1;
                        result.is_value   = 1'b1;
                        emit              = 1'b1;
                    end
                end
                ufd_pkg::ESC_PCT: begin
                    state_next.high_nibble  = ufd_pkg::hex_digit(in_byte);
                    state_next.escape_phase = ufd_pkg::ESC_HIGH;
                end
                ufd_pkg::ESC_HIGH: begin
                    result.out_byte   = {state.high_nibble, ufd_pkg::hex_digit(in_byte)};
                    result.byte_valid = 1'b1;
                    result.is_value   = 1'b1;
                    emit              = 1'b1;
                    state_next.escape_phase = ufd_pkg::ESC_NONE;
                    state_next.high_nibble  = 4'd0;
                end
                default: begin
                    state_next = ufd_pkg::STATE_RESET;
                end
            endcase
        end

        if (in_last) begin
            if (!result.pair_end) begin
                if (state_next.escape_phase != ufd_pkg::ESC_NONE) begin
                    result.out_byte   = ufd_pkg::cut_escape(state_next);
                    result.byte_valid = 1'b1;
                    result.is_value   = 1'b1;
                end
                result.pair_end       = 1'b1;
                result.pair_has_value = state_next.value_part;
            end
            result.final_res = 1'b1;
            emit             = 1'b1;
            state_next       = ufd_pkg::STATE_RESET;
        end
    end

endmodule

@@ hw/rtl/url_form_decoder.sv @@
// Channel   Direction  Handshake           Payload
// s_        input      s_valid / s_ready   s_in_byte, s_end_of_input
// m_        output     m_valid / m_ready   m_out_byte, m_byte_valid, m_is_value,
//                                          m_pair_end, m_pair_has_value, m_final_res
//
// One byte is taken per cycle while the result register is not stalled; a byte
// first lands in the input register and its result then in the result register.
// The result register is loaded in the same cycle as the state, when a step emits.
// Reset is synchronous on aresetn and returns the decoder to the start of a string.
// A stalled result register holds the input register, which then deasserts s_ready.
module url_form_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_is_value,
    output logic       m_pair_end,
    output logic       m_pair_has_value,
    output logic       m_final_res
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    ufd_pkg::dec_state_t  state_reg;
    ufd_pkg::dec_state_t  state_next;
    ufd_pkg::dec_result_t result_reg;
    ufd_pkg::dec_result_t step_result;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 step_emit;
    logic                 advance;

    ufd_step u_step (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .state_next (state_next),
        .result     (step_result),
        .emit       (step_emit)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = step_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= ufd_pkg::STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_end_of_input;
        end
        if (advance && step_emit) begin
            result_reg <= step_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = result_reg.out_byte;
    assign m_byte_valid     = result_reg.byte_valid;
    assign m_is_value       = result_reg.is_value;
    assign m_pair_end       = result_reg.pair_end;
    assign m_pair_has_value = result_reg.pair_has_value;
    assign m_final_res      = result_reg.final_res;

    // A pending escape only exists inside a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.escape_phase != ufd_pkg::ESC_NONE |-> state_reg.value_part)
        else $error("escape pending outside a value");

    // The last byte of a string always closes its pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_res |-> m_pair_end)
        else $error("final transfer without pair end");

    // Value flags only accompany the things they qualify.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_is_value || (m_pair_has_value && !m_pair_end)) |-> m_byte_valid)
        else $error("value flag without a byte");

    // After the last byte leaves the input stage the decoder is back at reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> state_reg == ufd_pkg::STATE_RESET)
        else $error("state not cleared after last byte");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TARGET_BYTES = 1950;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_input;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_is_value;
    logic       m_pair_end;
    logic       m_pair_has_value;
    logic       m_final_res;

    url_form_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_input  (s_end_of_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_is_value      (m_is_value),
        .m_pair_end      (m_pair_end),
        .m_pair_has_value(m_pair_has_value),
        .m_final_res     (m_final_res)
    );

    ufd_pkg::dec_result_t   decoded_q[$];
    logic                   dec_in_value;
    ufd_pkg::escape_phase_t dec_esc;
    logic [3:0]             dec_nib;

    int  cycle_count;
    int  bytes_sent;
    int  strings_sent;
    int  results_seen;
    int  pair_ends_seen;
    int  mismatch_count;
    int  hold_cycles;
    bit  s_gaps_on;
    bit  m_gaps_on;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
        if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
        return 4'd0;
    endfunction

    task automatic clear_decoder();
        dec_in_value = 1'b0;
        dec_esc = ufd_pkg::ESC_NONE;
        dec_nib = 4'd0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output bit emit, output ufd_pkg::dec_result_t r);
        r = '0;
        emit = 1'b0;
        if (b == ufd_pkg::CHAR_AMP) begin
            if (dec_esc != ufd_pkg::ESC_NONE) begin
                r.out_byte = (dec_esc == ufd_pkg::ESC_HIGH) ? {dec_nib, 4'h0} : 8'h00;
                r.byte_valid = 1'b1;
                r.is_value = 1'b1;
            end
            r.pair_end = 1'b1;
            r.pair_has_value = dec_in_value;
            emit = 1'b1;
            clear_decoder();
        end else if (!dec_in_value) begin
            if (b == ufd_pkg::CHAR_EQUALS) begin
                dec_in_value = 1'b1;
            end else begin
                r.out_byte = b;
                r.byte_valid = 1'b1;
                emit = 1'b1;
            end
        end else begin
            case (dec_esc)
                ufd_pkg::ESC_NONE: begin
                    if (b == ufd_pkg::CHAR_PERCENT) begin
                        dec_esc = ufd_pkg::ESC_PCT;
                    end else begin
                        r.out_byte = (b == ufd_pkg::CHAR_PLUS) ? ufd_pkg::CHAR_SPACE : b;
                        r.byte_valid = 1'b1;
                        r.is_value = 1'b1;
                        emit = 1'b1;
                    end
                end
                ufd_pkg::ESC_PCT: begin
                    dec_nib = nibble_of(b);
                    dec_esc = ufd_pkg::ESC_HIGH;
                end
                default: begin
                    r.out_byte = {dec_nib, nibble_of(b)};
                    r.byte_valid = 1'b1;
                    r.is_value = 1'b1;
                    emit = 1'b1;
                    dec_esc = ufd_pkg::ESC_NONE;
                    dec_nib = 4'd0;
                end
            endcase
        end
        if (last) begin
            if (!r.pair_end) begin
                if (dec_esc != ufd_pkg::ESC_NONE) begin
                    r.out_byte = (dec_esc == ufd_pkg::ESC_HIGH) ? {dec_nib, 4'h0} : 8'h00;
                    r.byte_valid = 1'b1;
                    r.is_value = 1'b1;
                end
                r.pair_end = 1'b1;
                r.pair_has_value = dec_in_value;
            end
            r.final_res = 1'b1;
            emit = 1'b1;
            clear_decoder();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        bit                   emit;
        ufd_pkg::dec_result_t r;
        @(negedge aclk);
        while (s_gaps_on && $urandom_range(0, 99) < 8) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_in_byte = b;
        s_end_of_input = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b, last, emit, r);
        if (emit) decoded_q.push_back(r);
        bytes_sent++;
        if (last) strings_sent++;
    endtask

    task automatic send_str(input string s, input bit close);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == ufd_pkg::CHAR_AMP || b == ufd_pkg::CHAR_EQUALS ||
                   b == ufd_pkg::CHAR_PERCENT);
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits = "0123456789abcdefABCDEF";
        if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
        return digits[$urandom_range(0, 21)];
    endfunction

    task automatic send_form(input bit well_formed);
        logic [7:0] q[$];
        int         n_pairs;
        int         n;
        if (well_formed) begin
            n_pairs = $urandom_range(1, 4);
            for (int p = 0; p < n_pairs; p++) begin
                if (p > 0) q.push_back(ufd_pkg::CHAR_AMP);
                n = $urandom_range(0, 4);
                repeat (n) q.push_back(plain_byte());
                if ($urandom_range(0, 99) < 85) begin
                    q.push_back(ufd_pkg::CHAR_EQUALS);
                    n = $urandom_range(0, 5);
                    for (int k = 0; k < n; k++) begin
                        case ($urandom_range(0, 9))
                            0, 1: q.push_back(ufd_pkg::CHAR_PLUS);
                            2, 3, 4: begin
                                q.push_back(ufd_pkg::CHAR_PERCENT);
                                q.push_back(hex_char());
                                q.push_back(hex_char());
                            end
                            5: q.push_back(ufd_pkg::CHAR_EQUALS);
                            default: q.push_back(plain_byte());
                        endcase
                    end
                end
            end
            case ($urandom_range(0, 9))
                0: q.push_back(ufd_pkg::CHAR_AMP);
                1: q.push_back(ufd_pkg::CHAR_PERCENT);
                2: begin
                    q.push_back(ufd_pkg::CHAR_PERCENT);
                    q.push_back(hex_char());
                end
                3: begin
                    q.push_back(ufd_pkg::CHAR_PERCENT);
                    q.push_back(hex_char());
                    q.push_back(ufd_pkg::CHAR_AMP);
                end
                default: ;
            endcase
            if (q.size() == 0) q.push_back(plain_byte());
        end else begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0: q.push_back(ufd_pkg::CHAR_AMP);
                    1: q.push_back(ufd_pkg::CHAR_PERCENT);
                    2: q.push_back(ufd_pkg::CHAR_EQUALS);
                    default: q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        for (int i = 0; i < q.size(); i++) begin
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready = 1'b0;
            hold_cycles--;
        end else begin
            m_ready = !(m_gaps_on && $urandom_range(0, 99) < 8);
        end
    end

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("tb: result %0d field %s expected %0h got %0h",
                         results_seen, field, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        ufd_pkg::dec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (decoded_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("tb: unexpected result, byte %0h pair_end %0b",
                             m_out_byte, m_pair_end);
                end
            end else begin
                want = decoded_q.pop_front();
                if (want.pair_end) pair_ends_seen++;
                check_field("out_byte", want.out_byte, m_out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(m_byte_valid));
                check_field("is_value", 8'(want.is_value), 8'(m_is_value));
                check_field("pair_end", 8'(want.pair_end), 8'(m_pair_end));
                check_field("pair_has_value", 8'(want.pair_has_value),
                            8'(m_pair_has_value));
                check_field("final_res", 8'(want.final_res), 8'(m_final_res));
            end
        end
    end

    // Empty pairs, escapes cut short by '&' and by the end of input, special
    // bytes in digit positions, a trailing '&', and the byte extremes.
    task automatic test_directed();
        send_str("&n=%4F+%z", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_str("=%a&%", 1'b1);
        send_str("=%+=", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ufd_pkg::CHAR_AMP, 1'b1);
        send_str("a=%", 1'b1);
    endtask

    task automatic test_backpressure();
        int start;
        start = bytes_sent;
        hold_cycles = 250;
        while (bytes_sent < start + 60) send_form(1'b1);
    endtask

    task automatic test_streaming();
        int start;
        start = bytes_sent;
        s_gaps_on = 1'b0;
        m_gaps_on = 1'b0;
        while (bytes_sent < start + 300) send_form($urandom_range(0, 99) < 80);
        s_gaps_on = 1'b1;
        m_gaps_on = 1'b1;
    endtask

    task automatic test_random();
        while (bytes_sent < TARGET_BYTES) send_form($urandom_range(0, 99) < 80);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_end_of_input = 1'b0;
        m_ready = 1'b0;
        s_gaps_on = 1'b1;
        m_gaps_on = 1'b1;
        hold_cycles = 0;
        clear_decoder();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_streaming();
        test_random();

        @(negedge aclk);
        s_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("tb: sent %0d bytes in %0d strings, checked %0d results (%0d pair ends)",
                 bytes_sent, strings_sent, results_seen, pair_ends_seen);
        $display("tb: covered escapes cut short, empty and trailing pairs, noise, %s",
                 "a long output hold-off and a gap-free stretch");
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d failures", mismatch_count);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
